FILE: rtl/tll_pkg.sv
// ----------------------------------------------------------------------------
// tll_pkg
// Shared types and constants of the lexer: token kinds, the token word,
// the reserved word table and the operator decode.
// ----------------------------------------------------------------------------
package tll_pkg;

	localparam int KIND_W = 5;
	localparam int LEN_W  = 4;
	localparam int TEXT_W = 64;

	typedef enum logic [KIND_W-1:0] {
		KIND_ENDFILE = 5'd0,
		KIND_ERROR   = 5'd1,
		KIND_IF      = 5'd2,
		KIND_THEN    = 5'd3,
		KIND_ELSE    = 5'd4,
		KIND_END     = 5'd5,
		KIND_REPEAT  = 5'd6,
		KIND_UNTIL   = 5'd7,
		KIND_READ    = 5'd8,
		KIND_WRITE   = 5'd9,
		KIND_ID      = 5'd10,
		KIND_NUM     = 5'd11,
		KIND_ASSIGN  = 5'd12,
		KIND_EQ      = 5'd13,
		KIND_LT      = 5'd14,
		KIND_PLUS    = 5'd15,
		KIND_MINUS   = 5'd16,
		KIND_TIMES   = 5'd17,
		KIND_OVER    = 5'd18,
		KIND_LPAREN  = 5'd19,
		KIND_RPAREN  = 5'd20,
		KIND_SEMI    = 5'd21
	} kind_t;

	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;

	localparam logic [TEXT_W-1:0] ASSIGN_TEXT = 64'h3d3a;

	localparam int KW_COUNT = 8;

	localparam logic [TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
		64'h0000_0000_0000_6669,
		64'h0000_0000_6e65_6874,
		64'h0000_0000_6573_6c65,
		64'h0000_0000_0064_6e65,
		64'h0000_7461_6570_6572,
		64'h0000_006c_6974_6e75,
		64'h0000_0000_6461_6572,
		64'h0000_0065_7469_7277
	};

	localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
		4'd2, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd4, 4'd5
	};

	localparam kind_t KW_KIND [KW_COUNT] = '{
		KIND_IF, KIND_THEN, KIND_ELSE, KIND_END,
		KIND_REPEAT, KIND_UNTIL, KIND_READ, KIND_WRITE
	};

	typedef struct packed {
		kind_t              kind;
		logic [LEN_W-1:0]   len;
		logic [TEXT_W-1:0]  text;
		logic               last;
	} token_t;

	typedef struct packed {
		logic   v0;
		logic   v1;
		token_t t0;
		token_t t1;
	} push_t;

	function automatic kind_t word_kind(input logic [TEXT_W-1:0] text,
		input logic [LEN_W-1:0] len);
		kind_t k;
		k = KIND_ID;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (text == KW_TEXT[i] && len == KW_LEN[i]) begin
				k = KW_KIND[i];
			end
		end
		return k;
	endfunction

	function automatic kind_t op_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			8'h3d: k = KIND_EQ;
			8'h3c: k = KIND_LT;
			8'h2b: k = KIND_PLUS;
			8'h2d: k = KIND_MINUS;
			8'h2a: k = KIND_TIMES;
			8'h2f: k = KIND_OVER;
			8'h28: k = KIND_LPAREN;
			8'h29: k = KIND_RPAREN;
			8'h3b: k = KIND_SEMI;
			default: k = KIND_ERROR;
		endcase
		return k;
	endfunction

endpackage

FILE: rtl/tll_scan.sv
// ----------------------------------------------------------------------------
// tll_scan
// Scanner automaton. Holds the scan mode and the lexeme buffer and turns one
// character into zero, one or two tokens, rescanning a terminating character
// from the start state in the same cycle.
// ----------------------------------------------------------------------------
module tll_scan import tll_pkg::*; #(
	parameter int TOKEN_CHARS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [7:0]  char_code,
	input  logic        end_of_input,
	output push_t       push
);

	localparam int CW = $clog2(TOKEN_CHARS + 2);

	typedef enum logic [4:0] {
		M_START   = 5'b00001,
		M_ASSIGN  = 5'b00010,
		M_COMMENT = 5'b00100,
		M_NUM     = 5'b01000,
		M_ID      = 5'b10000
	} mode_t;

	typedef struct packed {
		logic  emit;
		kind_t kind;
		logic  keep;
		mode_t mode;
	} start_t;

	mode_t                       mode_q, mode_n;
	logic [TOKEN_CHARS-1:0][7:0] store_q, store_n;
	logic [CW-1:0]               count_q, count_n;

	logic              is_digit, is_alpha, again, start_sel;
	logic [LEN_W-1:0]  cur_len;
	logic [TEXT_W-1:0] cur_text;
	token_t            tok_a, tok_b;
	logic              v_a, v_b;
	start_t            st;

	function automatic start_t start_step(input logic [7:0] c, input logic eof,
		input logic dig, input logic alp);
		start_t r;
		r.emit = 1'b0;
		r.kind = KIND_ERROR;
		r.keep = 1'b0;
		r.mode = M_START;
		if (eof) begin
			r.emit = 1'b1;
			r.kind = KIND_ENDFILE;
		end else if (dig) begin
			r.keep = 1'b1;
			r.mode = M_NUM;
		end else if (alp) begin
			r.keep = 1'b1;
			r.mode = M_ID;
		end else if (c == CH_COLON) begin
			r.keep = 1'b1;
			r.mode = M_ASSIGN;
		end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
			r.mode = M_START;
		end else if (c == CH_LBRACE) begin
			r.mode = M_COMMENT;
		end else begin
			r.emit = 1'b1;
			r.kind = op_kind(c);
		end
		return r;
	endfunction

	assign is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
	assign is_alpha = ((char_code >= 8'h61) && (char_code <= 8'h7a)) ||
		((char_code >= 8'h41) && (char_code <= 8'h5a));
	assign cur_len  = (count_q > CW'(TOKEN_CHARS)) ? LEN_W'(TOKEN_CHARS) : LEN_W'(count_q);
	assign cur_text = TEXT_W'(store_q);
	assign st       = start_step(char_code, end_of_input, is_digit, is_alpha);

	always_comb begin
		mode_n    = mode_q;
		store_n   = store_q;
		count_n   = count_q;
		again     = 1'b0;
		start_sel = 1'b0;
		v_a       = 1'b0;
		v_b       = 1'b0;
		tok_a     = '{kind: KIND_ENDFILE, len: '0, text: '0, last: 1'b0};
		tok_b     = '{kind: KIND_ENDFILE, len: '0, text: '0, last: 1'b0};
		unique case (mode_q)
			M_COMMENT: begin
				if (end_of_input) begin
					v_a     = 1'b1;
					mode_n  = M_START;
				end else if (char_code == CH_RBRACE) begin
					mode_n  = M_START;
				end
			end
			M_ASSIGN: begin
				mode_n = M_START;
				v_a    = 1'b1;
				if (!end_of_input && char_code == CH_EQ) begin
					tok_a.kind = KIND_ASSIGN;
					tok_a.len  = LEN_W'(2);
					tok_a.text = ASSIGN_TEXT;
				end else begin
					tok_a.kind = KIND_ERROR;
					tok_a.len  = cur_len;
					tok_a.text = cur_text;
					again      = 1'b1;
				end
			end
			M_NUM, M_ID: begin
				if (!end_of_input && ((mode_q == M_NUM) ? is_digit : is_alpha)) begin
					for (int i = 0; i < TOKEN_CHARS; i++) begin
						if (count_q == CW'(i)) begin
							store_n[i] = char_code;
						end
					end
					count_n = (count_q < CW'(TOKEN_CHARS)) ? count_q + CW'(1) :
						CW'(TOKEN_CHARS + 1);
				end else begin
					mode_n     = M_START;
					v_a        = 1'b1;
					again      = 1'b1;
					tok_a.len  = cur_len;
					tok_a.text = cur_text;
					if (mode_q == M_NUM) begin
						tok_a.kind = KIND_NUM;
					end else if (count_q > CW'(TOKEN_CHARS)) begin
						tok_a.kind = KIND_ID;
					end else begin
						tok_a.kind = word_kind(cur_text, cur_len);
					end
				end
			end
			default: begin
				start_sel = 1'b1;
			end
		endcase

		if (v_a) begin
			store_n = '0;
			count_n = '0;
		end

		if (start_sel || again) begin
			mode_n = st.mode;
			if (st.keep) begin
				store_n    = '0;
				store_n[0] = char_code;
				count_n    = CW'(1);
			end
			if (st.emit) begin
				if (start_sel) begin
					v_a        = 1'b1;
					tok_a.kind = st.kind;
					tok_a.len  = end_of_input ? '0 : LEN_W'(1);
					tok_a.text = end_of_input ? '0 : TEXT_W'(char_code);
				end else begin
					v_b        = 1'b1;
					tok_b.kind = st.kind;
					tok_b.len  = end_of_input ? '0 : LEN_W'(1);
					tok_b.text = end_of_input ? '0 : TEXT_W'(char_code);
				end
			end
		end

		tok_a.last = !v_b;
		tok_b.last = 1'b1;
	end

	assign push.v0 = fire && v_a;
	assign push.v1 = fire && v_b;
	assign push.t0 = tok_a;
	assign push.t1 = tok_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_START;
			store_q <= '0;
			count_q <= '0;
		end else if (fire) begin
			mode_q  <= mode_n;
			store_q <= store_n;
			count_q <= count_n;
		end
	end

endmodule

FILE: rtl/tll_tokq.sv
// ----------------------------------------------------------------------------
// tll_tokq
// Four-word token queue. Takes up to two tokens a cycle from the scanner and
// presents one word a cycle on the output channel while out_stall is low.
// ----------------------------------------------------------------------------
module tll_tokq import tll_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	output logic   room,
	output logic   out_valid,
	input  logic   out_stall,
	output token_t head
);

	localparam int QDEPTH = 4;
	localparam int PW     = $clog2(QDEPTH);
	localparam int CW     = $clog2(QDEPTH + 1);

	token_t        mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign room      = (count_q <= CW'(QDEPTH - 2));
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_ptr_q] <= push.t0;
		end
		if (push.v1) begin
			mem_q[wr_ptr_q + PW'(1)] <= push.t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.v0) + PW'(push.v1);
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			count_q  <= count_q + CW'(push.v0) + CW'(push.v1) - CW'(pop);
		end
	end

endmodule

FILE: rtl/tiny_language_lexer_unit.sv
// ----------------------------------------------------------------------------
// tiny_language_lexer_unit
// Scanner for the small teaching language, one source character per word.
//
// Each input word is captured in an input register, scanned once the token
// queue has room and its tokens written into a four-word token queue that
// drives the output port. The block accepts one character per cycle while
// in_stall is low; the output port delivers one token per cycle while
// out_stall is low. A character that ends a number, identifier or lone
// colon and also yields a token of its own puts two tokens into the queue,
// and the input stalls while a character waits and the queue holds more
// than two tokens. Lexemes keep at most TOKEN_CHARS bytes.
// ----------------------------------------------------------------------------
module tiny_language_lexer_unit import tll_pkg::*; #(
	parameter int TOKEN_CHARS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        char_code,
	input  logic              end_of_input,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [KIND_W-1:0] token_kind,
	output logic [LEN_W-1:0]  lexeme_length,
	output logic [TEXT_W-1:0] lexeme_text,
	output logic              last_of_run
);

	logic       valid_s1, char_ok;
	logic [7:0] char_s1;
	logic       eof_s1;
	logic       room, fire;
	push_t      push;
	token_t     head;

	assign fire     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign char_ok  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ok) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ok) begin
			char_s1 <= char_code;
			eof_s1  <= end_of_input;
		end
	end

	tll_scan #(.TOKEN_CHARS(TOKEN_CHARS)) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.char_code    (char_s1),
		.end_of_input (eof_s1),
		.push         (push)
	);

	tll_tokq u_tokq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign token_kind    = head.kind;
	assign lexeme_length = head.len;
	assign lexeme_text   = head.text;
	assign last_of_run   = head.last;

endmodule

FILE: rtl/tll_checker.sv
// ----------------------------------------------------------------------------
// tll_checker
// Port-level checks on the lexer's token stream, bound to the top level.
// ----------------------------------------------------------------------------
module tll_checker import tll_pkg::*; #(
	parameter int TOKEN_CHARS = 8
) (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [KIND_W-1:0] token_kind,
	input logic [LEN_W-1:0]  lexeme_length,
	input logic [TEXT_W-1:0] lexeme_text,
	input logic              last_of_run
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_kind) &&
		$stable(lexeme_length) && $stable(lexeme_text) && $stable(last_of_run))
		else $error("Token word changed while stalled.");

	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid)
		else $error("Second token of a run was not ready.");

	a_endfile: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_ENDFILE |->
		last_of_run && lexeme_length == '0 && lexeme_text == '0)
		else $error("End-of-file token is malformed.");

	a_assign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_ASSIGN |->
		lexeme_length == LEN_W'(2) && lexeme_text == ASSIGN_TEXT)
		else $error("Assign token is malformed.");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> token_kind <= KIND_SEMI &&
		lexeme_length <= LEN_W'(TOKEN_CHARS))
		else $error("Token kind or length out of range.");

endmodule

bind tiny_language_lexer_unit tll_checker #(.TOKEN_CHARS(TOKEN_CHARS)) u_tll_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.token_kind    (token_kind),
	.lexeme_length (lexeme_length),
	.lexeme_text   (lexeme_text),
	.last_of_run   (last_of_run)
);
